>>> rtl/core/rgba8_blend_mode_unit_top_defines.svh
// ----------------------------------------------------------------------------
// rgba8_blend_mode_unit_top_defines.svh
// Assertion macros for the blend unit's checker.
// ----------------------------------------------------------------------------
`ifndef RGBA8_BLEND_MODE_UNIT_TOP_DEFINES_SVH
`define RGBA8_BLEND_MODE_UNIT_TOP_DEFINES_SVH

// Same-cycle implication, sampled on i_clk, off during reset.
`define RGBABM_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off during reset.
`define RGBABM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/rgbabm_pkg.sv
// ----------------------------------------------------------------------------
// rgbabm_pkg
// Mode codes, stage-enable struct and byte-product helper for the blend unit.
// ----------------------------------------------------------------------------
package rgbabm_pkg;

    typedef enum logic [4:0] {
        MODE_CLEAR      = 5'd0,
        MODE_SRCATOP    = 5'd1,
        MODE_DSTATOP    = 5'd2,
        MODE_SRCIN      = 5'd3,
        MODE_DSTIN      = 5'd4,
        MODE_SRCOUT     = 5'd5,
        MODE_DSTOUT     = 5'd6,
        MODE_SRCOVER    = 5'd7,
        MODE_DSTOVER    = 5'd8,
        MODE_MODULATE   = 5'd9,
        MODE_MULTIPLY   = 5'd10,
        MODE_SCREEN     = 5'd11,
        MODE_XOR        = 5'd12,
        MODE_PLUS       = 5'd13,
        MODE_DARKEN     = 5'd14,
        MODE_LIGHTEN    = 5'd15,
        MODE_EXCLUSION  = 5'd16,
        MODE_DIFFERENCE = 5'd17
    } t_blend_mode;

    localparam t_blend_mode BLEND_MODE_RESET = MODE_SRCOVER;
    localparam int unsigned NUM_CHANNELS     = 4;
    localparam int unsigned ALPHA_CHANNEL    = 3;

    // Load strobes for the four lane stages.
    typedef struct packed {
        logic ld1;
        logic ld2;
        logic ld3;
        logic ld4;
    } t_stage_en;

    // Byte product approximation: (x*y + x) >> 8.
    function automatic logic [7:0] bmul(input logic [7:0] x, input logic [7:0] y);
        logic [15:0] prod;
        prod = (16'(x) * 16'(y)) + 16'(x);
        return prod[15:8];
    endfunction

endpackage

>>> rtl/core/rgbabm_lane.sv
// ----------------------------------------------------------------------------
// rgbabm_lane
// One byte channel of the blend datapath: products, mode blend, coverage
// products, final sum. Four register stages, loaded by the top's strobes.
// ----------------------------------------------------------------------------
module rgbabm_lane
    import rgbabm_pkg::*;
(
    input  logic        i_clk,
    input  t_stage_en   i_en,
    input  logic        i_is_alpha,
    input  logic [7:0]  i_src,
    input  logic [7:0]  i_dst,
    input  logic [7:0]  i_src_alpha,
    input  logic [7:0]  i_dst_alpha,
    input  logic [7:0]  i_coverage,
    input  t_blend_mode i_mode,
    output logic [7:0]  o_byte
);

    // stage 1: all byte products the modes draw on
    logic [7:0]  r1_src, r1_dst, r1_cov;
    t_blend_mode r1_mode;
    logic [7:0]  r1_s_da, r1_d_isa, r1_d_sa, r1_s_ida, r1_s_d, r1_is_d;

    always_ff @(posedge i_clk) begin
        if (i_en.ld1) begin
            r1_src   <= i_src;
            r1_dst   <= i_dst;
            r1_cov   <= i_coverage;
            r1_mode  <= i_mode;
            r1_s_da  <= bmul(i_src, i_dst_alpha);
            r1_d_isa <= bmul(i_dst, ~i_src_alpha);
            r1_d_sa  <= bmul(i_dst, i_src_alpha);
            r1_s_ida <= bmul(i_src, ~i_dst_alpha);
            r1_s_d   <= bmul(i_src, i_dst);
            r1_is_d  <= bmul(~i_src, i_dst);
        end
    end

    // stage 2: mode select, wrapping byte arithmetic except the saturating plus
    logic [7:0] sum_sd, min_pq, max_pq, n_blend;
    logic [8:0] wide_sd;

    always_comb begin
        sum_sd  = r1_src + r1_dst;
        wide_sd = {1'b0, r1_src} + {1'b0, r1_dst};
        min_pq  = (r1_s_da > r1_d_sa) ? r1_d_sa : r1_s_da;
        max_pq  = (r1_s_da > r1_d_sa) ? r1_s_da : r1_d_sa;
        case (r1_mode)
            MODE_CLEAR:      n_blend = 8'd0;
            MODE_SRCATOP:    n_blend = r1_s_da + r1_d_isa;
            MODE_DSTATOP:    n_blend = r1_d_sa + r1_s_ida;
            MODE_SRCIN:      n_blend = r1_s_da;
            MODE_DSTIN:      n_blend = r1_d_sa;
            MODE_SRCOUT:     n_blend = r1_s_ida;
            MODE_DSTOUT:     n_blend = r1_d_isa;
            MODE_SRCOVER:    n_blend = sum_sd - r1_d_sa;
            MODE_DSTOVER:    n_blend = sum_sd - r1_s_da;
            MODE_MODULATE:   n_blend = r1_s_d;
            MODE_MULTIPLY:   n_blend = r1_s_ida + r1_d_isa + r1_s_d;
            MODE_SCREEN:     n_blend = r1_src + r1_is_d;
            MODE_XOR:        n_blend = r1_s_ida + r1_d_isa;
            MODE_PLUS:       n_blend = wide_sd[8] ? 8'hff : wide_sd[7:0];
            MODE_DARKEN:     n_blend = i_is_alpha ? (sum_sd - r1_d_sa) : (sum_sd - max_pq);
            MODE_LIGHTEN:    n_blend = i_is_alpha ? (sum_sd - r1_d_sa) : (sum_sd - min_pq);
            MODE_EXCLUSION:  n_blend = i_is_alpha ? (sum_sd - r1_s_d)
                                                  : (sum_sd - r1_s_d - r1_s_d);
            MODE_DIFFERENCE: n_blend = i_is_alpha ? (sum_sd - min_pq)
                                                  : (sum_sd - min_pq - min_pq);
            default:         n_blend = 8'd0;
        endcase
    end

    logic [7:0] r2_blend, r2_dst, r2_cov;

    always_ff @(posedge i_clk) begin
        if (i_en.ld2) begin
            r2_blend <= n_blend;
            r2_dst   <= r1_dst;
            r2_cov   <= r1_cov;
        end
    end

    // stage 3: coverage weights
    logic [7:0] r3_blend_t, r3_dst_it;

    always_ff @(posedge i_clk) begin
        if (i_en.ld3) begin
            r3_blend_t <= bmul(r2_blend, r2_cov);
            r3_dst_it  <= bmul(r2_dst, ~r2_cov);
        end
    end

    // stage 4: output byte
    logic [7:0] r4_byte;

    always_ff @(posedge i_clk) begin
        if (i_en.ld4) begin
            r4_byte <= r3_blend_t + r3_dst_it;
        end
    end

    assign o_byte = r4_byte;

endmodule

>>> rtl/core/rgba8_blend_mode_unit_top.sv
// ----------------------------------------------------------------------------
// rgba8_blend_mode_unit_top
// Premultiplied RGBA8 blend under a configured mode, then coverage lerp
// toward the destination. Four-stage pipeline, one pixel per clock while o_stall is low.
// ----------------------------------------------------------------------------
//
//  channel | handshake              | payload
//  --------+------------------------+--------------------------------------
//  input   | i_valid / o_stall      | i_src_pixel, i_dst_pixel, i_coverage
//  output  | o_valid / i_stall      | o_result_pixel
//  config  | i_cfg_we               | i_cfg_wdata (blend mode)
//
//  An accepted word moves through stages 1 to 4 and is offered with o_valid
//  from the output register; a new word can be taken every cycle while
//  o_stall is low. Each stage holds its word only while the stage after it
//  is full and stalled, so o_stall rises only when all four stages are full
//  and i_stall is high. Bubbles close up under a stall. Reset (synchronous,
//  active low) empties the pipe and sets the mode to source-over.
//
module rgba8_blend_mode_unit_top
    import rgbabm_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input words
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_src_pixel,
    input  logic [31:0] i_dst_pixel,
    input  logic [7:0]  i_coverage,
    // result words
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_result_pixel,
    // configuration
    input  logic        i_cfg_we,
    input  logic [4:0]  i_cfg_wdata
);

    // Blend mode register; codes past the last mode fall through to clear.
    t_blend_mode r_blend_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_blend_mode <= BLEND_MODE_RESET;
        end else if (i_cfg_we) begin
            r_blend_mode <= t_blend_mode'(i_cfg_wdata);
        end
    end

    // Stage valids: bit 0 is stage 1, bit 3 is the output register.
    logic [3:0] r_valid, n_valid;
    logic [3:0] stage_rdy;
    t_stage_en  stage_en;

    // A stage can load when it is empty or its word moves on this cycle.
    always_comb begin
        stage_rdy[3] = !r_valid[3] || !i_stall;
        stage_rdy[2] = !r_valid[2] || stage_rdy[3];
        stage_rdy[1] = !r_valid[1] || stage_rdy[2];
        stage_rdy[0] = !r_valid[0] || stage_rdy[1];

        stage_en.ld1 = stage_rdy[0];
        stage_en.ld2 = stage_rdy[1];
        stage_en.ld3 = stage_rdy[2];
        stage_en.ld4 = stage_rdy[3];

        // Advance valids where a stage loads, hold them otherwise.
        n_valid[0] = stage_rdy[0] ? i_valid    : r_valid[0];
        n_valid[1] = stage_rdy[1] ? r_valid[0] : r_valid[1];
        n_valid[2] = stage_rdy[2] ? r_valid[1] : r_valid[2];
        n_valid[3] = stage_rdy[3] ? r_valid[2] : r_valid[3];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 4'b0000;
        end else begin
            r_valid <= n_valid;
        end
    end

    assign o_stall = !stage_rdy[0];
    assign o_valid = r_valid[3];

    // One lane per byte; the alpha lane takes the alpha-only rules.
    for (genvar ch = 0; ch < NUM_CHANNELS; ch++) begin : g_lane
        rgbabm_lane u_lane (
            .i_clk       (i_clk),
            .i_en        (stage_en),
            .i_is_alpha  (ch == ALPHA_CHANNEL),
            .i_src       (i_src_pixel[8*ch +: 8]),
            .i_dst       (i_dst_pixel[8*ch +: 8]),
            .i_src_alpha (i_src_pixel[31:24]),
            .i_dst_alpha (i_dst_pixel[31:24]),
            .i_coverage  (i_coverage),
            .i_mode      (r_blend_mode),
            .o_byte      (o_result_pixel[8*ch +: 8])
        );
    end

endmodule

>>> rtl/core/rgbabm_checker.sv
// ----------------------------------------------------------------------------
// rgbabm_checker
// Port-level checks on the blend unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "rgba8_blend_mode_unit_top_defines.svh"

module rgbabm_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [31:0] i_dst_pixel,
    input logic [7:0]  i_coverage,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_result_pixel
);

    // Result word waiting on a stalled receiver.
    logic out_held;
    assign out_held = o_valid && i_stall;

    // An accepted word, then the output free while the word moves up to the output register.
    sequence s_take;
        (i_valid && !o_stall) ##1 (!i_stall) [*3];
    endsequence

    sequence s_cov0;
        (i_valid && !o_stall && (i_coverage == 8'd0)) ##1 (!i_stall) [*3];
    endsequence

    // A stalled result word holds.
    `RGBABM_ASSERT_NEXT(a_out_hold, out_held, o_valid && $stable(o_result_pixel), "held word changed")

    // Input back-pressure only when the pipe is full and the output stalls.
    `RGBABM_ASSERT_NOW(a_stall_full, o_stall, out_held, "input stalled with room in the pipe")

    // With the output free, an accepted word reaches the output.
    `RGBABM_ASSERT_NEXT(a_latency, s_take, o_valid, "accepted word did not reach the output")

    // Zero coverage passes the destination through unchanged.
    `RGBABM_ASSERT_NEXT(a_zero_cov, s_cov0, o_result_pixel == $past(i_dst_pixel, 4), "dst not kept")

endmodule

bind rgba8_blend_mode_unit_top rgbabm_checker u_rgbabm_checker (.*);
